@@ sv/nvt_pkg.sv @@
`default_nettype none
package nvt_pkg;

  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned VALUE_WORDS_DEF = 4;
  localparam int unsigned KEY_BYTES_DEF   = 8;

  localparam int unsigned SHOWN_WORDS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_DEL  = 3'd1,
    FUNC_GET  = 3'd2,
    FUNC_SET  = 3'd3,
    FUNC_SIZE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NAME    = 3'd1,
    ST_LEN     = 3'd2,
    ST_NOVAL   = 3'd3,
    ST_NOTINIT = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  // classified command between front and back
  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] entry_key;
    logic [3:0]  value_length;
    logic        len_bad;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/named_value_table.sv @@
// A command passes the front queue, a key scan over all ENTRIES entries, an
// execute step and the result register, entered once that is free; a set
// adds a walk over the stored words of the hit entry before the result.
// The back takes a new command only when idle, paced by the key scan at one
// table entry per cycle; the front queue takes two items ahead.
// Reset: asynchronous, clears all valid bits, queue and result register.
`default_nettype none
module named_value_table #(
  parameter int unsigned ENTRIES     = nvt_pkg::ENTRIES_DEF,
  parameter int unsigned VALUE_WORDS = nvt_pkg::VALUE_WORDS_DEF,
  parameter int unsigned KEY_BYTES   = nvt_pkg::KEY_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func_i,
  input  wire logic [63:0] entry_key_i,
  input  wire logic [3:0]  value_length_i,
  input  wire logic [15:0] in_word0_i,
  input  wire logic [15:0] in_word1_i,
  input  wire logic [15:0] in_word2_i,
  input  wire logic [15:0] in_word3_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status_o,
  output logic [15:0]      out_word0_o,
  output logic [15:0]      out_word1_o,
  output logic [15:0]      out_word2_o,
  output logic [15:0]      out_word3_o,
  output logic             value_changed_o,
  output logic [4:0]       entry_count_o,
  output logic [7:0]       total_bytes_o
);

  logic          cmd_valid, cmd_ready;
  nvt_pkg::cmd_t cmd;

  nvt_front #(.VALUE_WORDS(VALUE_WORDS), .KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .func_i, .entry_key_i,
    .value_length_i, .in_word0_i, .in_word1_i, .in_word2_i, .in_word3_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  nvt_back #(.ENTRIES(ENTRIES), .VALUE_WORDS(VALUE_WORDS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid, .out_ready, .status_o, .out_word0_o,
    .out_word1_o, .out_word2_o, .out_word3_o, .value_changed_o,
    .entry_count_o, .total_bytes_o
  );

endmodule
`default_nettype wire

@@ sv/nvt_front.sv @@
`default_nettype none
module nvt_front #(
  parameter int unsigned VALUE_WORDS = nvt_pkg::VALUE_WORDS_DEF,
  parameter int unsigned KEY_BYTES   = nvt_pkg::KEY_BYTES_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   func_i,
  input  wire logic [63:0]  entry_key_i,
  input  wire logic [3:0]   value_length_i,
  input  wire logic [15:0]  in_word0_i,
  input  wire logic [15:0]  in_word1_i,
  input  wire logic [15:0]  in_word2_i,
  input  wire logic [15:0]  in_word3_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i,
  output nvt_pkg::cmd_t     cmd_o
);

  localparam int unsigned KEY_BITS = 8 * KEY_BYTES;
  localparam int unsigned PTR_W    = $clog2(nvt_pkg::QUEUE_DEPTH);

  nvt_pkg::cmd_t            queue_q [nvt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]           fill_q;
  nvt_pkg::cmd_t            cmd_in;
  logic [63:0]              key_mask;
  logic                     push, pop;

  assign key_mask = {64{1'b1}} >> (64 - KEY_BITS);

  always_comb begin
    cmd_in              = '0;
    cmd_in.func         = func_i;
    cmd_in.entry_key    = entry_key_i & key_mask;
    cmd_in.value_length = value_length_i;
    cmd_in.len_bad      = {1'b0, value_length_i} > 5'(VALUE_WORDS);
    cmd_in.word0        = in_word0_i;
    cmd_in.word1        = (VALUE_WORDS > 1) ? in_word1_i : '0;
    cmd_in.word2        = (VALUE_WORDS > 2) ? in_word2_i : '0;
    cmd_in.word3        = (VALUE_WORDS > 3) ? in_word3_i : '0;
  end

  assign in_ready    = fill_q != (PTR_W+1)'(nvt_pkg::QUEUE_DEPTH);
  assign push        = in_valid && in_ready;
  assign cmd_valid_o = fill_q != '0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      fill_q <= fill_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (PTR_W+1)'(nvt_pkg::QUEUE_DEPTH)) else $error("queue overfill");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> !push) else $error("push while full");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> fill_q == $past(fill_q) + 1'b1) else $error("fill slip");

endmodule
`default_nettype wire

@@ sv/nvt_back.sv @@
`default_nettype none
module nvt_back #(
  parameter int unsigned ENTRIES     = nvt_pkg::ENTRIES_DEF,
  parameter int unsigned VALUE_WORDS = nvt_pkg::VALUE_WORDS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_valid_i,
  output logic              cmd_ready_o,
  input  wire nvt_pkg::cmd_t cmd_i,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        status_o,
  output logic [15:0]       out_word0_o,
  output logic [15:0]       out_word1_o,
  output logic [15:0]       out_word2_o,
  output logic [15:0]       out_word3_o,
  output logic              value_changed_o,
  output logic [4:0]        entry_count_o,
  output logic [7:0]        total_bytes_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned LEN_W  = $clog2(VALUE_WORDS + 1);
  localparam int unsigned WIDX_W = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;
  localparam int unsigned BYTE_W = $clog2(2 * VALUE_WORDS * ENTRIES + 1);
  localparam int unsigned SHOWN  =
    (VALUE_WORDS < nvt_pkg::SHOWN_WORDS) ? VALUE_WORDS : nvt_pkg::SHOWN_WORDS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_WORD = 4'b1000
  } state_e;

  state_e              state_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [63:0]         keys_q [ENTRIES];
  logic [LEN_W-1:0]    lens_q [ENTRIES];
  logic [15:0]         words_q [ENTRIES][VALUE_WORDS];

  nvt_pkg::cmd_t       cmd_q;
  logic [CNT_W-1:0]    idx_q;
  logic                hit_q, free_found_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [BYTE_W-1:0]   bytes_q;
  logic [WIDX_W:0]     widx_q;
  logic                changed_q;

  logic                res_full_q;
  logic [2:0]          status_q;
  logic [15:0]         ow_q [nvt_pkg::SHOWN_WORDS];
  logic                chg_out_q;
  logic [4:0]          cnt_out_q;
  logic [7:0]          bytes_out_q;

  logic [IDX_W-1:0]    scan_idx, hit_i;
  logic [15:0]         new_word;
  logic [WIDX_W-1:0]   wsel;
  logic                take, finish, res_free, walk_done;
  logic [2:0]          fin_status;

  assign scan_idx    = idx_q[IDX_W-1:0];
  assign hit_i       = hit_idx_q;
  assign wsel        = widx_q[WIDX_W-1:0];
  assign cmd_ready_o = (state_q == S_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  // the result register is free when empty or emptied at this edge
  assign res_free    = !res_full_q || (out_valid && out_ready);
  assign walk_done   = widx_q >= (WIDX_W+1)'(lens_q[hit_i]);

  always_comb begin
    case (widx_q)
      0:       new_word = cmd_q.word0;
      1:       new_word = cmd_q.word1;
      2:       new_word = cmd_q.word2;
      3:       new_word = cmd_q.word3;
      default: new_word = '0;
    endcase
  end

  always_comb begin
    fin_status = nvt_pkg::ST_OK;
    case (cmd_q.func)
      nvt_pkg::FUNC_ADD:
        if (hit_q) fin_status = nvt_pkg::ST_NAME;
        else if (cmd_q.len_bad) fin_status = nvt_pkg::ST_LEN;
        else if (!free_found_q) fin_status = nvt_pkg::ST_FULL;
      nvt_pkg::FUNC_DEL:
        if (cnt_q == '0) fin_status = nvt_pkg::ST_NOVAL;
        else if (!hit_q) fin_status = nvt_pkg::ST_NAME;
      nvt_pkg::FUNC_GET, nvt_pkg::FUNC_SET:
        if (!hit_q) fin_status = nvt_pkg::ST_NAME;
      nvt_pkg::FUNC_SIZE:
        if (cnt_q == '0) fin_status = nvt_pkg::ST_NOTINIT;
      default: fin_status = nvt_pkg::ST_OK;
    endcase
  end

  // finish the transaction at EXEC, or once the set word walk is done;
  // hold until the result register is free
  assign finish = res_free &&
                  ((state_q == S_EXEC &&
                    !(cmd_q.func == nvt_pkg::FUNC_SET && hit_q)) ||
                   (state_q == S_WORD && walk_done));

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    if (state_q == S_EXEC && cmd_q.func == nvt_pkg::FUNC_ADD && !hit_q &&
        !cmd_q.len_bad && free_found_q) begin
      keys_q[free_idx_q] <= cmd_q.entry_key;
      lens_q[free_idx_q] <= LEN_W'(cmd_q.value_length);
      for (int i = 0; i < SHOWN; i++) begin
        if (i < cmd_q.value_length) begin
          case (i)
            0:       words_q[free_idx_q][i] <= cmd_q.word0;
            1:       words_q[free_idx_q][i] <= cmd_q.word1;
            2:       words_q[free_idx_q][i] <= cmd_q.word2;
            default: words_q[free_idx_q][i] <= cmd_q.word3;
          endcase
        end
      end
      for (int i = SHOWN; i < VALUE_WORDS; i++) begin
        if (i < cmd_q.value_length) words_q[free_idx_q][i] <= '0;
      end
    end
    if (state_q == S_WORD && !walk_done)
      words_q[hit_i][wsel] <= new_word;
    if (finish) begin
      status_q    <= fin_status;
      chg_out_q   <= 1'b0;
      cnt_out_q   <= '0;
      bytes_out_q <= '0;
      for (int i = 0; i < nvt_pkg::SHOWN_WORDS; i++) ow_q[i] <= '0;
      if (cmd_q.func == nvt_pkg::FUNC_GET && hit_q) begin
        for (int i = 0; i < SHOWN; i++) begin
          if (i < lens_q[hit_i]) ow_q[i] <= words_q[hit_i][i];
        end
      end
      if (cmd_q.func == nvt_pkg::FUNC_SET && hit_q) chg_out_q <= changed_q;
      if (cmd_q.func == nvt_pkg::FUNC_SIZE) begin
        cnt_out_q   <= 5'(cnt_q);
        bytes_out_q <= 8'(bytes_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      cnt_q        <= '0;
      bytes_q      <= '0;
      widx_q       <= '0;
      changed_q    <= 1'b0;
      res_full_q   <= 1'b0;
    end else begin
      if (out_valid && out_ready) res_full_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            state_q      <= S_SCAN;
            idx_q        <= '0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            cnt_q        <= '0;
            bytes_q      <= '0;
          end
        end
        S_SCAN: begin
          // one entry per cycle: match, first free slot, count and bytes
          if (valid_q[scan_idx]) begin
            cnt_q   <= cnt_q + 1'b1;
            bytes_q <= bytes_q + BYTE_W'({lens_q[scan_idx], 1'b0});
            if (!hit_q && keys_q[scan_idx] == cmd_q.entry_key) begin
              hit_q     <= 1'b1;
              hit_idx_q <= scan_idx;
            end
          end else if (!free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= scan_idx;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == CNT_W'(ENTRIES - 1)) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_q.func == nvt_pkg::FUNC_ADD && !hit_q && !cmd_q.len_bad &&
              free_found_q)
            valid_q[free_idx_q] <= 1'b1;
          if (cmd_q.func == nvt_pkg::FUNC_DEL && hit_q)
            valid_q[hit_idx_q] <= 1'b0;
          if (cmd_q.func == nvt_pkg::FUNC_SET && hit_q) begin
            state_q   <= S_WORD;
            widx_q    <= '0;
            changed_q <= 1'b0;
          end else if (finish) begin
            state_q    <= S_IDLE;
            res_full_q <= 1'b1;
          end
        end
        S_WORD: begin
          if (!walk_done) begin
            if (words_q[hit_i][wsel] != new_word) changed_q <= 1'b1;
            widx_q <= widx_q + 1'b1;
          end else if (finish) begin
            state_q    <= S_IDLE;
            res_full_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = res_full_q;
  assign status_o        = status_q;
  assign out_word0_o     = ow_q[0];
  assign out_word1_o     = ow_q[1];
  assign out_word2_o     = ow_q[2];
  assign out_word3_o     = ow_q[3];
  assign value_changed_o = chg_out_q;
  assign entry_count_o   = cnt_out_q;
  assign total_bytes_o   = bytes_out_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_ready_o) else $error("command taken while busy");
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(status_q))
    else $error("result lost");

endmodule
`default_nettype wire

@@ bench/named_value_table_test.sv @@
`timescale 1ns / 1ps
module named_value_table_test;

  localparam int NSLOT = 16;
  localparam int NWORD = 4;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic        changed;
    logic [4:0]  count;
    logic [7:0]  bytes;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] func_i = '0;
  logic [63:0] entry_key_i = '0;
  logic [3:0] value_length_i = '0;
  logic [15:0] in_word0_i = '0, in_word1_i = '0, in_word2_i = '0, in_word3_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status_o;
  logic [15:0] out_word0_o, out_word1_o, out_word2_o, out_word3_o;
  logic value_changed_o;
  logic [4:0] entry_count_o;
  logic [7:0] total_bytes_o;

  named_value_table DUT (.*);

  // shadow of the table
  bit          tbl_used[NSLOT];
  logic [63:0] tbl_key[NSLOT];
  logic [2:0]  tbl_len[NSLOT];
  logic [15:0] tbl_word[NSLOT][NWORD];

  answer_t pending_answers[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  longint cycles = 0;
  logic [63:0] known_keys[$];

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("named_value_table test failed");
      $finish;
    end
  end

  function automatic int lookup(logic [63:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic answer_t apply_op(logic [2:0] fn, logic [63:0] key, logic [3:0] len,
                                       logic [15:0] w[NWORD]);
    answer_t a;
    int s;
    int f;
    int n;
    int b;
    a = '0;
    s = lookup(key);
    f = -1;
    n = 0;
    b = 0;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i]) begin
        n++;
        b += 2 * tbl_len[i];
      end else if (f < 0) f = i;
    case (fn)
      nvt_pkg::FUNC_ADD: begin
        if (s >= 0) a.status = nvt_pkg::ST_NAME;
        else if (len > NWORD) a.status = nvt_pkg::ST_LEN;
        else if (f < 0) a.status = nvt_pkg::ST_FULL;
        else begin
          tbl_used[f] = 1'b1;
          tbl_key[f] = key;
          tbl_len[f] = len[2:0];
          for (int i = 0; i < len; i++) tbl_word[f][i] = w[i];
        end
      end
      nvt_pkg::FUNC_DEL: begin
        if (n == 0) a.status = nvt_pkg::ST_NOVAL;
        else if (s < 0) a.status = nvt_pkg::ST_NAME;
        else tbl_used[s] = 1'b0;
      end
      nvt_pkg::FUNC_GET: begin
        if (s < 0) a.status = nvt_pkg::ST_NAME;
        else begin
          if (tbl_len[s] > 0) a.w0 = tbl_word[s][0];
          if (tbl_len[s] > 1) a.w1 = tbl_word[s][1];
          if (tbl_len[s] > 2) a.w2 = tbl_word[s][2];
          if (tbl_len[s] > 3) a.w3 = tbl_word[s][3];
        end
      end
      nvt_pkg::FUNC_SET: begin
        if (s < 0) a.status = nvt_pkg::ST_NAME;
        else
          for (int i = 0; i < tbl_len[s]; i++) begin
            if (tbl_word[s][i] != w[i]) a.changed = 1'b1;
            tbl_word[s][i] = w[i];
          end
      end
      nvt_pkg::FUNC_SIZE: begin
        a.status = (n == 0) ? nvt_pkg::ST_NOTINIT : nvt_pkg::ST_OK;
        a.count = n[4:0];
        a.bytes = b[7:0];
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_op(logic [2:0] fn, logic [63:0] key, logic [3:0] len,
                         logic [15:0] w0, logic [15:0] w1, logic [15:0] w2, logic [15:0] w3);
    logic [15:0] w[NWORD];
    w = '{w0, w1, w2, w3};
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func_i <= fn;
    entry_key_i <= key;
    value_length_i <= len;
    in_word0_i <= w0;
    in_word1_i <= w1;
    in_word2_i <= w2;
    in_word3_i <= w3;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_answers.push_back(apply_op(fn, key, len, w));
    items_sent++;
  endtask

  // receiver stalls and result checks
  always @(posedge clk_i) begin
    answer_t e;
    answer_t got;
    if (out_valid && out_ready) begin
      got = '{status_o, out_word0_o, out_word1_o, out_word2_o, out_word3_o,
              value_changed_o, entry_count_o, total_bytes_o};
      results_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing pending: %h", $time, got);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (got.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        if (got.w0 !== e.w0) $display("%0t: word0 expected %h actual %h", $time, e.w0, got.w0);
        if (got.w1 !== e.w1) $display("%0t: word1 expected %h actual %h", $time, e.w1, got.w1);
        if (got.w2 !== e.w2) $display("%0t: word2 expected %h actual %h", $time, e.w2, got.w2);
        if (got.w3 !== e.w3) $display("%0t: word3 expected %h actual %h", $time, e.w3, got.w3);
        if (got.changed !== e.changed)
          $display("%0t: changed expected %0d actual %0d", $time, e.changed, got.changed);
        if (got.count !== e.count)
          $display("%0t: count expected %0d actual %0d", $time, e.count, got.count);
        if (got.bytes !== e.bytes)
          $display("%0t: bytes expected %0d actual %0d", $time, e.bytes, got.bytes);
        if (got !== e) errors++;
      end
    end
    if (rst_ni) out_ready <= calm || ($urandom_range(99) >= 27);
  end

  function automatic logic [63:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(99) < 75)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_op(int add_bias);
    logic [2:0] fn;
    logic [63:0] key;
    logic [3:0] len;
    int r;
    r = $urandom_range(99);
    if (r < add_bias) fn = nvt_pkg::FUNC_ADD;
    else if (r < 97) fn = 3'($urandom_range(1, 4));
    else fn = 3'($urandom_range(5, 7));
    key = pick_key();
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(4));
    if (fn == nvt_pkg::FUNC_ADD && known_keys.size() < 40) known_keys.push_back(key);
    send_op(fn, key, len, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_op(nvt_pkg::FUNC_SIZE, 64'h0, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_DEL, 64'h1, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_GET, 64'h1, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_SET, 64'h1, 0, 1, 2, 3, 4);
    send_op(nvt_pkg::FUNC_ADD, 64'h0, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_ADD, '1, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(nvt_pkg::FUNC_ADD, '1, 4, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_ADD, 64'h2, 15, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_ADD, 64'h3, 5, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_ADD, 64'h4, 2, 16'hA5A5, 16'h5A5A, 16'h1111, 16'h2222);
    send_op(nvt_pkg::FUNC_GET, 64'h4, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_GET, '1, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_SET, 64'h4, 0, 16'hA5A5, 16'h5A5A, 16'h7, 16'h7);
    send_op(nvt_pkg::FUNC_SET, '1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0);
    send_op(nvt_pkg::FUNC_SET, 64'h0, 0, 1, 1, 1, 1);
    send_op(nvt_pkg::FUNC_SIZE, 64'h0, 0, 0, 0, 0, 0);
    send_op(3'd5, 64'h4, 3, 1, 2, 3, 4);
    send_op(3'd7, '1, 15, '1, '1, '1, '1);
    for (int i = 0; i < 14; i++) send_op(nvt_pkg::FUNC_ADD, 64'h100 + i, 4, i, i, i, i);
    send_op(nvt_pkg::FUNC_ADD, 64'h999, 1, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_SIZE, 64'h0, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_DEL, 64'h0, 0, 0, 0, 0, 0);
    send_op(nvt_pkg::FUNC_ADD, 64'h999, 3, 9, 8, 7, 0);
    send_op(nvt_pkg::FUNC_DEL, 64'h12345, 0, 0, 0, 0, 0);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i]) send_op(nvt_pkg::FUNC_DEL, tbl_key[i], 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 900; i++) random_op(i % 200 < 100 ? 45 : 20);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    for (int i = 0; i < 300; i++) random_op(30);
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d transactions in, %0d results checked", items_sent, results_seen);
    $display("all five operations, unknown codes, full and empty table, length errors");
    if (errors == 0) begin
      $display("named_value_table test passed");
    end else begin
      $display("named_value_table test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/nvt_pkg.sv
sv/nvt_front.sv
sv/nvt_back.sv
sv/named_value_table.sv
bench/named_value_table_test.sv
